// File: hdl/brm_pkg.sv
// Package of the bytecode register machine: instruction kinds, status codes,
// the queue entry and the status bundle shared by the front, back and top.
// Depends on nothing.
`default_nettype none
package brm_pkg;

  localparam int NumRegsDef    = 8;
  localparam int MemBytesDef   = 4096;
  localparam int StackDepthDef = 1024;
  localparam int CallDepthDef  = 256;
  localparam logic [15:0] ProgLenReset = 16'd4096;

  localparam logic [3:0] ST_RUN     = 4'd0;
  localparam logic [3:0] ST_HALT    = 4'd1;
  localparam logic [3:0] ST_DONE    = 4'd2;
  localparam logic [3:0] ST_DIVZ    = 4'd3;
  localparam logic [3:0] ST_MEM     = 4'd4;
  localparam logic [3:0] ST_SOVER   = 4'd5;
  localparam logic [3:0] ST_SUNDER  = 4'd6;
  localparam logic [3:0] ST_COVER   = 4'd7;
  localparam logic [3:0] ST_BADRET  = 4'd8;
  localparam logic [3:0] ST_RAISE   = 4'd9;
  localparam logic [3:0] ST_UNKNOWN = 4'd10;

  localparam logic [7:0] OPC_NOP   = 8'd0;
  localparam logic [7:0] OPC_HALT  = 8'd1;
  localparam logic [7:0] OPC_MOV   = 8'd10;
  localparam logic [7:0] OPC_LOAD  = 8'd11;
  localparam logic [7:0] OPC_STORE = 8'd12;
  localparam logic [7:0] OPC_ADD   = 8'd20;
  localparam logic [7:0] OPC_SUB   = 8'd21;
  localparam logic [7:0] OPC_MUL   = 8'd22;
  localparam logic [7:0] OPC_DIV   = 8'd23;
  localparam logic [7:0] OPC_JMP   = 8'd40;
  localparam logic [7:0] OPC_JIF   = 8'd41;
  localparam logic [7:0] OPC_CALL  = 8'd42;
  localparam logic [7:0] OPC_RET   = 8'd43;
  localparam logic [7:0] OPC_PUSH  = 8'd50;
  localparam logic [7:0] OPC_POP   = 8'd51;
  localparam logic [7:0] OPC_TRYB  = 8'd60;
  localparam logic [7:0] OPC_TRYE  = 8'd61;
  localparam logic [7:0] OPC_RAISE = 8'd62;
  localparam logic [7:0] OPC_CATCH = 8'd63;
  localparam logic [7:0] OPC_FINIT = 8'd70;
  localparam logic [7:0] OPC_FNEXT = 8'd71;

  typedef enum logic [4:0] {
    K_NOP, K_HALT, K_MOV, K_LOAD, K_STORE, K_ADD, K_SUB, K_MUL, K_DIV,
    K_JMP, K_JIF, K_CALL, K_RET, K_PUSH, K_POP, K_RAISE, K_CATCH,
    K_FINIT, K_FNEXT, K_UNK
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  len;
    logic [2:0]  ra;
    logic [2:0]  rb;
    logic [2:0]  rc;
    logic [15:0] tgt;
    logic        cond;
    logic [31:0] imm;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [3:0] stop;
    logic       clearing;
    logic       pop;
  } dbg_t;

endpackage
`default_nettype wire

// File: hdl/brm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module brm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// File: hdl/brm_front.sv
// Front end: accepts instruction beats, classifies the opcode and its length,
// and holds them in a two-entry queue for the back end. Uses brm_pkg.
`default_nettype none
module brm_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire logic [65:0]    data_i,
  input  wire logic           pop_i,
  output brm_pkg::head_t      head_o
);
  brm_pkg::item_t ent_q [2];
  brm_pkg::item_t dec;
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push;

  always_comb begin
    dec.ra   = data_i[10:8];
    dec.rb   = data_i[13:11];
    dec.rc   = data_i[16:14];
    dec.tgt  = data_i[32:17];
    dec.cond = data_i[33];
    dec.imm  = data_i[65:34];
    unique case (data_i[7:0])
      brm_pkg::OPC_NOP:   begin dec.kind = brm_pkg::K_NOP;   dec.len = 3'd1; end
      brm_pkg::OPC_HALT:  begin dec.kind = brm_pkg::K_HALT;  dec.len = 3'd1; end
      brm_pkg::OPC_MOV:   begin dec.kind = brm_pkg::K_MOV;   dec.len = 3'd3; end
      brm_pkg::OPC_LOAD:  begin dec.kind = brm_pkg::K_LOAD;  dec.len = 3'd4; end
      brm_pkg::OPC_STORE: begin dec.kind = brm_pkg::K_STORE; dec.len = 3'd4; end
      brm_pkg::OPC_ADD:   begin dec.kind = brm_pkg::K_ADD;   dec.len = 3'd4; end
      brm_pkg::OPC_SUB:   begin dec.kind = brm_pkg::K_SUB;   dec.len = 3'd4; end
      brm_pkg::OPC_MUL:   begin dec.kind = brm_pkg::K_MUL;   dec.len = 3'd4; end
      brm_pkg::OPC_DIV:   begin dec.kind = brm_pkg::K_DIV;   dec.len = 3'd4; end
      brm_pkg::OPC_JMP:   begin dec.kind = brm_pkg::K_JMP;   dec.len = 3'd0; end
      brm_pkg::OPC_JIF:   begin dec.kind = brm_pkg::K_JIF;   dec.len = 3'd4; end
      brm_pkg::OPC_CALL:  begin dec.kind = brm_pkg::K_CALL;  dec.len = 3'd3; end
      brm_pkg::OPC_RET:   begin dec.kind = brm_pkg::K_RET;   dec.len = 3'd1; end
      brm_pkg::OPC_PUSH:  begin dec.kind = brm_pkg::K_PUSH;  dec.len = 3'd2; end
      brm_pkg::OPC_POP:   begin dec.kind = brm_pkg::K_POP;   dec.len = 3'd2; end
      brm_pkg::OPC_TRYB:  begin dec.kind = brm_pkg::K_NOP;   dec.len = 3'd3; end
      brm_pkg::OPC_TRYE:  begin dec.kind = brm_pkg::K_NOP;   dec.len = 3'd1; end
      brm_pkg::OPC_RAISE: begin dec.kind = brm_pkg::K_RAISE; dec.len = 3'd0; end
      brm_pkg::OPC_CATCH: begin dec.kind = brm_pkg::K_CATCH; dec.len = 3'd2; end
      brm_pkg::OPC_FINIT: begin dec.kind = brm_pkg::K_FINIT; dec.len = 3'd6; end
      brm_pkg::OPC_FNEXT: begin dec.kind = brm_pkg::K_FNEXT; dec.len = 3'd4; end
      default:            begin dec.kind = brm_pkg::K_UNK;   dec.len = 3'd1; end
    endcase
  end

  assign ready_o = (cnt_q != 2'd2);
  assign push    = valid_i && ready_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = ent_q[rp_q];
endmodule
`default_nettype wire

// File: hdl/brm_back.sv
// Back end: register file, byte-lane data memory, data and return stacks,
// iterative divider and the result register. Uses brm_pkg and brm_ram.
`default_nettype none
module brm_back #(
  parameter int NUM_REGS    = brm_pkg::NumRegsDef,
  parameter int MEM_BYTES   = brm_pkg::MemBytesDef,
  parameter int STACK_DEPTH = brm_pkg::StackDepthDef,
  parameter int RET_DEPTH   = brm_pkg::CallDepthDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  brm_pkg::head_t      head_i,
  output logic                pop_o,
  input  wire logic [15:0]    plen_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output logic [55:0]         data_o,
  output brm_pkg::dbg_t       dbg_o
);
  localparam int RW   = $clog2(NUM_REGS);
  localparam int MW   = (MEM_BYTES + 3) / 4;
  localparam int LAW  = (MW > 1) ? $clog2(MW) : 1;
  localparam int SAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SCW  = $clog2(STACK_DEPTH + 1);
  localparam int CAW  = (RET_DEPTH > 1) ? $clog2(RET_DEPTH) : 1;
  localparam int CCW  = $clog2(RET_DEPTH + 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_DIV   = 5'b01000,
    S_DFIN  = 5'b10000
  } state_e;

  function automatic logic [RW-1:0] ridx(input logic [2:0] v);
    logic [4:0] t;
    t = {2'b00, v};
    for (int i = 0; i < 4; i++) begin
      if (t >= 5'(NUM_REGS)) t = t - 5'(NUM_REGS);
    end
    return t[RW-1:0];
  endfunction

  function automatic logic [LAW-1:0] lane_word(input logic [15:0] t, input logic [1:0] k);
    logic [1:0]  off;
    logic [16:0] b;
    off = k - t[1:0];
    b   = {1'b0, t} + {15'd0, off};
    return b[LAW+1:2];
  endfunction

  state_e state_q;
  brm_pkg::item_t cur_q;
  logic [31:0] rf_q [NUM_REGS];
  logic [15:0] pc_q;
  logic [3:0]  stop_q;
  logic [SCW-1:0] sc_q;
  logic [CCW-1:0] cd_q;
  logic [LAW:0]   clr_q;

  logic [32:0] rem_q;
  logic [31:0] quo_q, den_q;
  logic        neg_q;
  logic [4:0]  dcnt_q;

  logic        out_v_q;
  logic [55:0] out_q;

  // memory lanes
  logic [LAW-1:0] ln_raddr [4];
  logic [LAW-1:0] ln_waddr [4];
  logic [7:0]     ln_wdata [4];
  logic [7:0]     ln_rdata [4];
  logic           ln_we;

  logic [SCW-1:0] sc_m1;
  logic [CCW-1:0] cd_m1;
  logic [31:0] ds_rdata;
  logic [15:0] rs_rdata;

  logic        free, run, go_div, commit;
  logic [3:0]  status;
  logic [15:0] npc;
  logic        wv;
  logic [31:0] val;
  logic        do_store, do_push, do_pop, do_call, do_ret;
  logic [RW-1:0] ia, ib, ic;
  logic [31:0] va, vb, vc;
  logic [31:0] mem_word, dres, prod;
  logic [32:0] rem_sh;
  logic        mem_oob;

  assign free  = !out_v_q || ready_i;
  assign pop_o = (state_q == S_IDLE) && head_i.valid;
  assign sc_m1 = sc_q - SCW'(1);
  assign cd_m1 = cd_q - CCW'(1);

  assign ia = ridx(cur_q.ra);
  assign ib = ridx(cur_q.rb);
  assign ic = ridx(cur_q.rc);
  assign va = rf_q[ia];
  assign vb = rf_q[ib];
  assign vc = rf_q[ic];
  assign prod = vb * vc;
  assign dres = neg_q ? (32'd0 - quo_q) : quo_q;
  assign mem_oob = ({1'b0, cur_q.tgt} + 17'd4) > 17'(MEM_BYTES);
  assign run = (stop_q == brm_pkg::ST_RUN) && (pc_q < plen_i);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mem_word[8*i +: 8] = ln_rdata[2'(cur_q.tgt[1:0] + 2'(i))];
    end
  end

  always_comb begin
    status = brm_pkg::ST_RUN;
    npc = pc_q;
    wv = 1'b0;
    val = 32'd0;
    do_store = 1'b0;
    do_push = 1'b0;
    do_pop = 1'b0;
    do_call = 1'b0;
    do_ret = 1'b0;
    if (stop_q != brm_pkg::ST_RUN) begin
      status = stop_q;
    end else if (pc_q >= plen_i) begin
      status = brm_pkg::ST_DONE;
    end else begin
      unique case (cur_q.kind)
        brm_pkg::K_NOP:  npc = pc_q + 16'(cur_q.len);
        brm_pkg::K_HALT: begin npc = pc_q + 16'd1; status = brm_pkg::ST_HALT; end
        brm_pkg::K_MOV:  begin wv = 1'b1; val = vb; npc = pc_q + 16'(cur_q.len); end
        brm_pkg::K_ADD:  begin wv = 1'b1; val = vb + vc; npc = pc_q + 16'd4; end
        brm_pkg::K_SUB:  begin wv = 1'b1; val = vb - vc; npc = pc_q + 16'd4; end
        brm_pkg::K_MUL:  begin wv = 1'b1; val = prod; npc = pc_q + 16'd4; end
        brm_pkg::K_DIV: begin
          if (vc == 32'd0) status = brm_pkg::ST_DIVZ;
          else begin wv = 1'b1; val = dres; npc = pc_q + 16'd4; end
        end
        brm_pkg::K_LOAD: begin
          if (mem_oob) status = brm_pkg::ST_MEM;
          else begin wv = 1'b1; val = mem_word; npc = pc_q + 16'd4; end
        end
        brm_pkg::K_STORE: begin
          if (mem_oob) status = brm_pkg::ST_MEM;
          else begin do_store = 1'b1; npc = pc_q + 16'd4; end
        end
        brm_pkg::K_JMP: npc = cur_q.tgt;
        brm_pkg::K_JIF: npc = (cur_q.cond && rf_q[0] != 32'd0) ? cur_q.tgt : pc_q + 16'd4;
        brm_pkg::K_CALL: begin
          if (cd_q >= CCW'(RET_DEPTH)) status = brm_pkg::ST_COVER;
          else begin do_call = 1'b1; npc = cur_q.tgt; end
        end
        brm_pkg::K_RET: begin
          if (cd_q == '0) status = brm_pkg::ST_BADRET;
          else begin do_ret = 1'b1; npc = rs_rdata; end
        end
        brm_pkg::K_PUSH: begin
          if (sc_q >= SCW'(STACK_DEPTH)) status = brm_pkg::ST_SOVER;
          else begin do_push = 1'b1; npc = pc_q + 16'd2; end
        end
        brm_pkg::K_POP: begin
          if (sc_q == '0) status = brm_pkg::ST_SUNDER;
          else begin do_pop = 1'b1; wv = 1'b1; val = ds_rdata; npc = pc_q + 16'd2; end
        end
        brm_pkg::K_RAISE: status = brm_pkg::ST_RAISE;
        brm_pkg::K_CATCH: begin wv = 1'b1; val = 32'd1; npc = pc_q + 16'd2; end
        brm_pkg::K_FINIT: begin wv = 1'b1; val = cur_q.imm; npc = pc_q + 16'd6; end
        brm_pkg::K_FNEXT: begin
          wv = 1'b1;
          val = va - 32'd1;
          npc = val[31] ? (pc_q + 16'd4) : cur_q.tgt;
        end
        brm_pkg::K_UNK: begin npc = pc_q + 16'd1; status = brm_pkg::ST_UNKNOWN; end
        default: npc = pc_q;
      endcase
    end
  end

  assign go_div = (state_q == S_EXEC) && (cur_q.kind == brm_pkg::K_DIV) && run &&
                  (vc != 32'd0);
  assign commit = free && (((state_q == S_EXEC) && !go_div) || (state_q == S_DFIN));

  // lane addressing: reads come from the queue head, writes from the clear
  // sweep or the committing store
  always_comb begin
    ln_we = (state_q == S_CLEAR) || (commit && do_store);
    for (int k = 0; k < 4; k++) begin
      ln_raddr[k] = lane_word(head_i.item.tgt, 2'(k));
      if (state_q == S_CLEAR) begin
        ln_waddr[k] = clr_q[LAW-1:0];
        ln_wdata[k] = 8'd0;
      end else begin
        ln_waddr[k] = lane_word(cur_q.tgt, 2'(k));
        ln_wdata[k] = va[8*(2'(2'(k) - cur_q.tgt[1:0])) +: 8];
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    brm_ram #(.WIDTH(8), .DEPTH(MW), .AW(LAW)) u_mem (
      .clk_i   (clk_i),
      .we_i    (ln_we),
      .waddr_i (ln_waddr[k]),
      .wdata_i (ln_wdata[k]),
      .re_i    (pop_o),
      .raddr_i (ln_raddr[k]),
      .rdata_o (ln_rdata[k])
    );
  end

  brm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH), .AW(SAW)) u_dstack (
    .clk_i   (clk_i),
    .we_i    (commit && do_push),
    .waddr_i (sc_q[SAW-1:0]),
    .wdata_i (va),
    .re_i    (pop_o),
    .raddr_i (sc_m1[SAW-1:0]),
    .rdata_o (ds_rdata)
  );

  brm_ram #(.WIDTH(16), .DEPTH(RET_DEPTH), .AW(CAW)) u_rstack (
    .clk_i   (clk_i),
    .we_i    (commit && do_call),
    .waddr_i (cd_q[CAW-1:0]),
    .wdata_i (pc_q + 16'd3),
    .re_i    (pop_o),
    .raddr_i (cd_m1[CAW-1:0]),
    .rdata_o (rs_rdata)
  );

  assign rem_sh = {rem_q[31:0], quo_q[31]};

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i.item;
    if (go_div) begin
      rem_q <= 33'd0;
      quo_q <= vb[31] ? (32'd0 - vb) : vb;
      den_q <= vc[31] ? (32'd0 - vc) : vc;
      neg_q <= vb[31] ^ vc[31];
    end else if (state_q == S_DIV) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    if (commit) begin
      out_q <= {wv ? val : 32'd0, wv ? 3'(ia) : 3'd0, wv, npc, status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pc_q    <= 16'd0;
      stop_q  <= brm_pkg::ST_RUN;
      sc_q    <= '0;
      cd_q    <= '0;
      dcnt_q  <= 5'd0;
      out_v_q <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= 32'd0;
    end else begin
      if (ready_i) out_v_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (LAW+1)'(MW - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (pop_o) state_q <= S_EXEC;
        S_EXEC: begin
          if (go_div) begin
            dcnt_q  <= 5'd0;
            state_q <= S_DIV;
          end else if (commit) begin
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd31) state_q <= S_DFIN;
        end
        S_DFIN: if (commit) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      if (commit) begin
        out_v_q <= 1'b1;
        if (run) begin
          pc_q <= npc;
          if (wv) rf_q[ia] <= val;
          if (do_push) sc_q <= sc_q + SCW'(1);
          if (do_pop)  sc_q <= sc_m1;
          if (do_call) cd_q <= cd_q + CCW'(1);
          if (do_ret)  cd_q <= cd_m1;
          if (status != brm_pkg::ST_RUN && status != brm_pkg::ST_UNKNOWN) stop_q <= status;
        end else if (status == brm_pkg::ST_DONE) begin
          stop_q <= brm_pkg::ST_DONE;
        end
      end
    end
  end

  assign valid_o        = out_v_q;
  assign data_o         = out_q;
  assign dbg_o.stop     = stop_q;
  assign dbg_o.clearing = (state_q == S_CLEAR);
  assign dbg_o.pop      = pop_o;
endmodule
`default_nettype wire

// File: hdl/bytecode_register_machine.sv
// Top level of the bytecode register machine: program length register,
// front end, back end and checks. Uses brm_pkg, brm_front and brm_back.
`default_nettype none
// Executes one pre-decoded instruction per input beat and returns one result
// beat per instruction. A two-entry queue sits behind the input, so beats are
// taken while the back end works or while a result waits to be taken. Most
// instructions take three steps in the back end (queue pop with memory and
// stack reads, execute, result); a divide with a nonzero divisor also runs
// its one-bit-per-cycle divider between execute and result. After reset the
// data memory is swept to zero before the first instruction executes; the
// configuration channel is taken at all times. A halt, the end of the
// program or a fault other than an unknown opcode stops the machine, and
// every later beat repeats that status.
module bytecode_register_machine #(
  parameter int NUM_REGS    = brm_pkg::NumRegsDef,
  parameter int MEM_BYTES   = brm_pkg::MemBytesDef,
  parameter int STACK_DEPTH = brm_pkg::StackDepthDef,
  parameter int RET_DEPTH   = brm_pkg::CallDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // opcode[7:0] reg_a[10:8] reg_b[13:11] reg_c[16:14] target_address[32:17]
  // condition[33] immediate[65:34], zero padded
  input  wire logic [71:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[3:0] next_pc[19:4] write_valid[20] write_reg[23:21] write_value[55:24]
  output logic [55:0]      m_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);
  logic [15:0] plen_q;
  logic        pop;
  brm_pkg::head_t head;
  brm_pkg::dbg_t  dbg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= brm_pkg::ProgLenReset;
    end else if (cfg_valid_i) begin
      plen_q <= cfg_data_i;
    end
  end

  brm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_tvalid),
    .ready_o (s_tready),
    .data_i  (s_tdata[65:0]),
    .pop_i   (pop),
    .head_o  (head)
  );

  brm_back #(
    .NUM_REGS(NUM_REGS), .MEM_BYTES(MEM_BYTES),
    .STACK_DEPTH(STACK_DEPTH), .RET_DEPTH(RET_DEPTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .pop_o   (pop),
    .plen_i  (plen_q),
    .valid_o (m_tvalid),
    .ready_i (m_tready),
    .data_o  (m_tdata),
    .dbg_o   (dbg)
  );

  // Once stopped, the machine stays stopped with the same status.
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dbg.stop != brm_pkg::ST_RUN) |=> (dbg.stop == $past(dbg.stop)))
    else $error("stop status changed after the machine stopped");

  // No instruction leaves the queue while memory is still being cleared.
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbg.clearing |-> !dbg.pop)
    else $error("instruction issued during memory clear");

  // A register write is only reported by an instruction that ran normally.
  a_write_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tdata[20]) |-> (m_tdata[3:0] == brm_pkg::ST_RUN))
    else $error("register write reported with a stop status");
endmodule
`default_nettype wire

// File: tb/bytecode_register_machine_tb.sv
// Self-checking bench for the bytecode register machine: a queue-fed stream
// driver, a stalling receiver, and an in-bench model of the machine state.
// Depends on brm_pkg and bytecode_register_machine.
`timescale 1ns / 100ps
`default_nettype none
module bytecode_register_machine_tb;

  typedef struct {
    logic [7:0]  opcode;
    logic [2:0]  ra;
    logic [2:0]  rb;
    logic [2:0]  rc;
    logic [15:0] tgt;
    logic        cond;
    logic [31:0] imm;
  } instr_t;

  typedef struct {
    logic [3:0]  status;
    logic [15:0] next_pc;
    logic        wr_en;
    logic [2:0]  wr_reg;
    logic [31:0] wr_val;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  bytecode_register_machine DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the machine state.
  logic [31:0] gpr [8];
  logic [7:0]  dmem [4096];
  logic [31:0] dstk [1024];
  int          dstk_cnt;
  logic [15:0] rstk [256];
  int          rstk_dep;
  logic [15:0] pc_q;
  logic [3:0]  halt_code;
  int          prog_len;

  instr_t   instr_q[$];
  outcome_t result_q[$];
  int       fail_cnt = 0;

  // Executes one instruction on the shadow state and returns what the
  // machine should report for it.
  function automatic outcome_t execute(instr_t it);
    outcome_t r;
    logic [31:0] sum;
    longint q;
    int unsigned npc;
    r.status = brm_pkg::ST_RUN;
    r.wr_en = 1'b0;
    r.wr_reg = '0;
    r.wr_val = '0;
    npc = pc_q;
    if (halt_code != brm_pkg::ST_RUN) begin
      r.status = halt_code;
    end else if (int'(pc_q) >= prog_len) begin
      r.status = brm_pkg::ST_DONE;
      halt_code = brm_pkg::ST_DONE;
    end else begin
      case (it.opcode)
        brm_pkg::OPC_NOP, brm_pkg::OPC_TRYE: npc = pc_q + 1;
        brm_pkg::OPC_HALT: begin
          npc = pc_q + 1;
          r.status = brm_pkg::ST_HALT;
        end
        brm_pkg::OPC_MOV: begin
          r.wr_en = 1'b1; r.wr_val = gpr[it.rb]; npc = pc_q + 3;
        end
        brm_pkg::OPC_ADD, brm_pkg::OPC_SUB, brm_pkg::OPC_MUL: begin
          r.wr_en = 1'b1; npc = pc_q + 4;
          if (it.opcode == brm_pkg::OPC_ADD) r.wr_val = gpr[it.rb] + gpr[it.rc];
          else if (it.opcode == brm_pkg::OPC_SUB) r.wr_val = gpr[it.rb] - gpr[it.rc];
          else r.wr_val = gpr[it.rb] * gpr[it.rc];
        end
        brm_pkg::OPC_DIV: begin
          if (gpr[it.rc] == 0) begin
            r.status = brm_pkg::ST_DIVZ;
          end else begin
            // Done in 64 bits so that the most negative value over -1 wraps.
            q = longint'($signed(gpr[it.rb])) / longint'($signed(gpr[it.rc]));
            r.wr_en = 1'b1; r.wr_val = q[31:0]; npc = pc_q + 4;
          end
        end
        brm_pkg::OPC_LOAD, brm_pkg::OPC_STORE: begin
          if (int'(it.tgt) + 4 > 4096) begin
            r.status = brm_pkg::ST_MEM;
          end else if (it.opcode == brm_pkg::OPC_LOAD) begin
            r.wr_en = 1'b1; npc = pc_q + 4;
            r.wr_val = {dmem[it.tgt + 3], dmem[it.tgt + 2], dmem[it.tgt + 1], dmem[it.tgt]};
          end else begin
            sum = gpr[it.ra];
            for (int i = 0; i < 4; i++) dmem[it.tgt + i] = sum[8*i +: 8];
            npc = pc_q + 4;
          end
        end
        brm_pkg::OPC_JMP: npc = it.tgt;
        brm_pkg::OPC_JIF: npc = (it.cond && gpr[0] != 0) ? it.tgt : pc_q + 4;
        brm_pkg::OPC_CALL: begin
          if (rstk_dep >= 256) begin
            r.status = brm_pkg::ST_COVER;
          end else begin
            rstk[rstk_dep] = pc_q + 3;
            rstk_dep++;
            npc = it.tgt;
          end
        end
        brm_pkg::OPC_RET: begin
          if (rstk_dep == 0) begin
            r.status = brm_pkg::ST_BADRET;
          end else begin
            rstk_dep--;
            npc = rstk[rstk_dep];
          end
        end
        brm_pkg::OPC_PUSH: begin
          if (dstk_cnt >= 1024) begin
            r.status = brm_pkg::ST_SOVER;
          end else begin
            dstk[dstk_cnt] = gpr[it.ra];
            dstk_cnt++;
            npc = pc_q + 2;
          end
        end
        brm_pkg::OPC_POP: begin
          if (dstk_cnt == 0) begin
            r.status = brm_pkg::ST_SUNDER;
          end else begin
            dstk_cnt--;
            r.wr_en = 1'b1; r.wr_val = dstk[dstk_cnt]; npc = pc_q + 2;
          end
        end
        brm_pkg::OPC_TRYB: npc = pc_q + 3;
        brm_pkg::OPC_RAISE: r.status = brm_pkg::ST_RAISE;
        brm_pkg::OPC_CATCH: begin
          r.wr_en = 1'b1; r.wr_val = 32'd1; npc = pc_q + 2;
        end
        brm_pkg::OPC_FINIT: begin
          r.wr_en = 1'b1; r.wr_val = it.imm; npc = pc_q + 6;
        end
        brm_pkg::OPC_FNEXT: begin
          r.wr_en = 1'b1; r.wr_val = gpr[it.ra] - 32'd1;
          npc = r.wr_val[31] ? pc_q + 4 : it.tgt;
        end
        default: begin
          npc = pc_q + 1;
          r.status = brm_pkg::ST_UNKNOWN;
        end
      endcase
      if (r.wr_en) begin
        r.wr_reg = it.ra;
        gpr[it.ra] = r.wr_val;
      end
      pc_q = npc[15:0];
      if (r.status != brm_pkg::ST_RUN && r.status != brm_pkg::ST_UNKNOWN)
        halt_code = r.status;
    end
    r.next_pc = pc_q;
    return r;
  endfunction

  function automatic bit is_known(logic [7:0] op);
    case (op)
      brm_pkg::OPC_NOP, brm_pkg::OPC_HALT, brm_pkg::OPC_MOV, brm_pkg::OPC_LOAD,
      brm_pkg::OPC_STORE, brm_pkg::OPC_ADD, brm_pkg::OPC_SUB, brm_pkg::OPC_MUL,
      brm_pkg::OPC_DIV, brm_pkg::OPC_JMP, brm_pkg::OPC_JIF, brm_pkg::OPC_CALL,
      brm_pkg::OPC_RET, brm_pkg::OPC_PUSH, brm_pkg::OPC_POP, brm_pkg::OPC_TRYB,
      brm_pkg::OPC_TRYE, brm_pkg::OPC_RAISE, brm_pkg::OPC_CATCH, brm_pkg::OPC_FINIT,
      brm_pkg::OPC_FNEXT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic instr_t rand_fields(logic [7:0] op);
    instr_t it;
    it.opcode = op;
    it.ra = $urandom_range(0, 7);
    it.rb = $urandom_range(0, 7);
    it.rc = $urandom_range(0, 7);
    it.tgt = $urandom_range(0, 65535);
    it.cond = $urandom_range(0, 1);
    it.imm = $urandom;
    return it;
  endfunction

  function automatic instr_t make(logic [7:0] op, int a, int b, int c, int t,
                                 logic [31:0] k);
    instr_t it;
    it = rand_fields(op);
    it.ra = a; it.rb = b; it.rc = c; it.tgt = t; it.imm = k; it.cond = 1'b1;
    return it;
  endfunction

  function automatic void queue_raw(instr_t it);
    instr_q.push_back(it);
    result_q.push_back(execute(it));
  endfunction

  // Keeps a running program inside its length by jumping back to its start
  // half whenever the pc gets close to the end.
  function automatic void queue_instr(instr_t it);
    instr_t jb;
    if (halt_code == brm_pkg::ST_RUN && int'(pc_q) + 6 >= prog_len) begin
      jb = rand_fields(brm_pkg::OPC_JMP);
      jb.tgt = $urandom_range(0, prog_len / 2);
      queue_raw(jb);
    end
    queue_raw(it);
  endfunction

  // A random instruction that keeps the machine running.
  function automatic instr_t safe_instr();
    instr_t it;
    int pick;
    int hi;
    pick = $urandom_range(0, 99);
    hi = (prog_len > 8) ? prog_len - 1 : 0;
    if (pick < 5) begin
      do it = rand_fields($urandom_range(0, 255)); while (is_known(it.opcode));
      return it;
    end
    case ($urandom_range(0, 19))
      0:  it = rand_fields(brm_pkg::OPC_NOP);
      1:  it = rand_fields(brm_pkg::OPC_MOV);
      2:  it = rand_fields(brm_pkg::OPC_ADD);
      3:  it = rand_fields(brm_pkg::OPC_SUB);
      4:  it = rand_fields(brm_pkg::OPC_MUL);
      5:  it = rand_fields(brm_pkg::OPC_DIV);
      6:  it = rand_fields(brm_pkg::OPC_LOAD);
      7:  it = rand_fields(brm_pkg::OPC_STORE);
      8:  it = rand_fields(brm_pkg::OPC_JMP);
      9:  it = rand_fields(brm_pkg::OPC_JIF);
      10: it = rand_fields(brm_pkg::OPC_CALL);
      11: it = rand_fields(brm_pkg::OPC_RET);
      12: it = rand_fields(brm_pkg::OPC_PUSH);
      13: it = rand_fields(brm_pkg::OPC_POP);
      14: it = rand_fields(brm_pkg::OPC_TRYB);
      15: it = rand_fields(brm_pkg::OPC_TRYE);
      16: it = rand_fields(brm_pkg::OPC_CATCH);
      17: it = rand_fields(brm_pkg::OPC_FINIT);
      default: it = rand_fields(brm_pkg::OPC_FNEXT);
    endcase
    if (it.opcode == brm_pkg::OPC_FINIT && $urandom_range(0, 3) == 0)
      it.imm = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    if (it.opcode == brm_pkg::OPC_DIV && gpr[it.rc] == 0) it.opcode = brm_pkg::OPC_MUL;
    if (it.opcode == brm_pkg::OPC_POP && dstk_cnt == 0) it.opcode = brm_pkg::OPC_PUSH;
    else if (it.opcode == brm_pkg::OPC_PUSH && dstk_cnt >= 1024)
      it.opcode = brm_pkg::OPC_POP;
    if (it.opcode == brm_pkg::OPC_RET && rstk_dep == 0) it.opcode = brm_pkg::OPC_CALL;
    else if (it.opcode == brm_pkg::OPC_CALL && rstk_dep >= 256)
      it.opcode = brm_pkg::OPC_RET;
    // A return address left over from a longer program would end the run.
    if (it.opcode == brm_pkg::OPC_RET && rstk_dep != 0 &&
        int'(rstk[rstk_dep - 1]) >= prog_len)
      it.opcode = brm_pkg::OPC_NOP;
    // Memory accesses mostly land in a small window so loads see stores.
    if (it.opcode == brm_pkg::OPC_LOAD || it.opcode == brm_pkg::OPC_STORE)
      it.tgt = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4092) : $urandom_range(0, 60);
    else
      it.tgt = $urandom_range(0, hi);
    return it;
  endfunction

  task automatic drain();
    while (instr_q.size() != 0 || result_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_length(int v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    prog_len = v;
  endtask

  // Each phase starts from pc zero so that a shorter length does not end it.
  task automatic random_phase(int len, int count);
    if (halt_code == brm_pkg::ST_RUN) begin
      @(negedge clk_i);
      queue_raw(make(brm_pkg::OPC_JMP, 0, 0, 0, 0, 0));
      drain();
    end
    write_length(len);
    @(negedge clk_i);
    for (int i = 0; i < count; i++) queue_instr(safe_instr());
    drain();
  endtask

  // Sender: bursts of beats with random gaps between them.
  int burst_left;
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      burst_left = 0;
      gap_left = 0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid) void'(instr_q.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (instr_q.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, instr_q[0].imm, instr_q[0].cond, instr_q[0].tgt,
                    instr_q[0].rc, instr_q[0].rb, instr_q[0].ra, instr_q[0].opcode};
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stretches of no, light and heavy stalling, plus one long
  // hold-off so that the input queue fills and back-pressures the sender.
  int seg_left;
  int seg_mode;
  int hold_left;
  int taken_cnt;
  bit long_hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      seg_left = 0;
      seg_mode = 0;
      hold_left = 0;
      taken_cnt = 0;
      long_hold_done = 1'b0;
    end else begin
      if (m_tvalid && m_tready) taken_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!long_hold_done && taken_cnt >= 120) begin
        long_hold_done = 1'b1;
        hold_left = 400;
        m_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 80);
          seg_mode = $urandom_range(0, 2);
        end else begin
          seg_left--;
        end
        case (seg_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= $urandom_range(0, 3) != 0;
          default: m_tready <= $urandom_range(0, 9) < 3;
        endcase
      end
    end
  end

  // Monitor: every result beat is checked against the oldest expectation.
  outcome_t want;
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result beat %h", m_tdata);
        fail_cnt++;
      end else begin
        want = result_q.pop_front();
        if (m_tdata[3:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[3:0]);
          fail_cnt++;
        end
        if (m_tdata[19:4] !== want.next_pc) begin
          $error("next_pc: expected %0d, got %0d", want.next_pc, m_tdata[19:4]);
          fail_cnt++;
        end
        if (m_tdata[20] !== want.wr_en) begin
          $error("write_valid: expected %0d, got %0d", want.wr_en, m_tdata[20]);
          fail_cnt++;
        end
        if (m_tdata[23:21] !== want.wr_reg) begin
          $error("write_reg: expected %0d, got %0d", want.wr_reg, m_tdata[23:21]);
          fail_cnt++;
        end
        if (m_tdata[55:24] !== want.wr_val) begin
          $error("write_value: expected %h, got %h", want.wr_val, m_tdata[55:24]);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("bytecode_register_machine: mismatch");
    $finish;
  end

  initial begin
    instr_t it;
    int cause;
    int rc0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    dstk_cnt = 0;
    rstk_dep = 0;
    pc_q = '0;
    halt_code = brm_pkg::ST_RUN;
    prog_len = 4096;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening at the reset program length: arithmetic wrap,
    // truncating and wrapping divides, memory edges, stacks and branches.
    queue_instr(make(brm_pkg::OPC_FINIT, 1, 0, 0, 0, 32'h7fff_ffff));
    queue_instr(make(brm_pkg::OPC_FINIT, 2, 0, 0, 0, 32'hffff_ffff));
    queue_instr(make(brm_pkg::OPC_FINIT, 3, 0, 0, 0, 32'h8000_0000));
    queue_instr(make(brm_pkg::OPC_ADD, 4, 1, 1, 0, 0));
    queue_instr(make(brm_pkg::OPC_SUB, 5, 3, 1, 0, 0));
    queue_instr(make(brm_pkg::OPC_MUL, 6, 1, 1, 0, 0));
    queue_instr(make(brm_pkg::OPC_DIV, 6, 3, 2, 0, 0));
    queue_instr(make(brm_pkg::OPC_FINIT, 7, 0, 0, 0, -32'sd7));
    queue_instr(make(brm_pkg::OPC_FINIT, 0, 0, 0, 0, 32'd2));
    queue_instr(make(brm_pkg::OPC_DIV, 5, 7, 0, 0, 0));
    queue_instr(make(brm_pkg::OPC_MOV, 4, 7, 0, 0, 0));
    queue_instr(make(brm_pkg::OPC_LOAD, 1, 0, 0, 4092, 0));
    queue_instr(make(brm_pkg::OPC_STORE, 3, 0, 0, 4092, 0));
    queue_instr(make(brm_pkg::OPC_LOAD, 5, 0, 0, 4092, 0));
    queue_instr(make(brm_pkg::OPC_PUSH, 7, 0, 0, 0, 0));
    queue_instr(make(brm_pkg::OPC_POP, 2, 0, 0, 0, 0));
    queue_instr(make(brm_pkg::OPC_CALL, 0, 0, 0, 200, 0));
    queue_instr(make(brm_pkg::OPC_RET, 0, 0, 0, 0, 0));
    queue_instr(make(brm_pkg::OPC_TRYB, 0, 0, 0, 0, 0));
    queue_instr(make(brm_pkg::OPC_TRYE, 0, 0, 0, 0, 0));
    queue_instr(make(brm_pkg::OPC_CATCH, 6, 0, 0, 0, 0));
    queue_instr(make(brm_pkg::OPC_JIF, 0, 0, 0, 300, 0));
    queue_instr(make(brm_pkg::OPC_FNEXT, 0, 0, 0, 50, 0));
    queue_instr(make(brm_pkg::OPC_FNEXT, 7, 0, 0, 60, 0));
    queue_instr(make(8'd30, 0, 0, 0, 0, 0));
    drain();

    // Random phases; the sender waits for every result between them.
    random_phase(65535, 170);
    random_phase($urandom_range(64, 65534), 160);
    random_phase(16, 150);
    random_phase(4096, 150);

    // Finish with one stopping event, then items the stopped machine ignores.
    cause = $urandom_range(0, 8);
    if (cause == 8) begin
      write_length(0);
    end
    @(negedge clk_i);
    case (cause)
      0: queue_instr(make(brm_pkg::OPC_HALT, 0, 0, 0, 0, 0));
      1: begin
        rc0 = $urandom_range(0, 7);
        queue_instr(make(brm_pkg::OPC_FINIT, rc0, 0, 0, 0, 0));
        queue_instr(make(brm_pkg::OPC_DIV, $urandom_range(0, 7), $urandom_range(0, 7),
                         rc0, 0, 0));
      end
      2: queue_instr(make($urandom_range(0, 1) ? brm_pkg::OPC_LOAD : brm_pkg::OPC_STORE,
                          1, 0, 0, $urandom_range(4093, 65535), 0));
      3: while (halt_code == brm_pkg::ST_RUN)
           queue_instr(make(brm_pkg::OPC_PUSH, $urandom_range(0, 7), 0, 0, 0, 0));
      4: while (halt_code == brm_pkg::ST_RUN)
           queue_instr(make(brm_pkg::OPC_POP, $urandom_range(0, 7), 0, 0, 0, 0));
      5: while (halt_code == brm_pkg::ST_RUN)
           queue_instr(make(brm_pkg::OPC_CALL, 0, 0, 0,
                            $urandom_range(0, prog_len - 8), 0));
      6: while (halt_code == brm_pkg::ST_RUN)
           queue_instr(make(brm_pkg::OPC_RET, 0, 0, 0, 0, 0));
      7: queue_instr(make(brm_pkg::OPC_RAISE, 0, 0, 0, 0, 0));
      default: queue_instr(make(brm_pkg::OPC_NOP, 0, 0, 0, 0, 0));
    endcase
    for (int i = 0; i < 12; i++) queue_raw(rand_fields($urandom_range(0, 255)));
    drain();

    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("bytecode_register_machine: match");
    end else begin
      $display("bytecode_register_machine: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
